// ===== rtl/q15cpc_pkg.sv =====
// ----------------------------------------------------------------------------
// q15cpc_pkg: shared types and constants for the q15 product chain
// fixed-point constants, register index codes and the clamp/shift helper
// ----------------------------------------------------------------------------
package q15cpc_pkg;

  localparam int unsigned SampleW   = 16;
  localparam int unsigned CountW    = 4;
  localparam int unsigned CfgDataW  = 4;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned SumW      = 2 * SampleW + 1;
  localparam int unsigned Q15Shift  = 15;
  localparam int unsigned HwMaxCount = 8;

  localparam logic signed [SampleW-1:0] Q15One  = 16'sh7fff;
  localparam logic signed [SampleW-1:0] Q15Min  = 16'sh8000;
  localparam logic signed [SumW-1:0]    SatHi   = 33'sh0_3fff_ffff;
  localparam logic signed [SumW-1:0]    SatLo   = -33'sh0_4000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_COMPLEX_MODE = 1'b0,
    CFG_FACTOR_COUNT = 1'b1
  } cfg_reg_e;

  typedef logic signed [SampleW-1:0] q15_t;
  typedef logic signed [SumW-1:0]    wide_t;

  // clamp to the signed 31-bit range, then floor-shift right by 15
  function automatic q15_t sat_shift(input wide_t v);
    q15_t r;
    if (v > SatHi) begin
      r = Q15One;
    end else if (v < SatLo) begin
      r = Q15Min;
    end else begin
      r = v[Q15Shift+SampleW-1:Q15Shift];
    end
    return r;
  endfunction

endpackage

// ===== rtl/q15cpc_if.sv =====
// ----------------------------------------------------------------------------
// q15cpc interfaces: valid/ready channels of the q15 product chain
// factor sample words in, finished product words out
// ----------------------------------------------------------------------------
interface q15cpc_sample_if;
  import q15cpc_pkg::*;

  logic valid;
  logic ready;
  q15_t sample_re;
  q15_t sample_im;
  logic block_end;

  modport source (output valid, output sample_re, output sample_im, output block_end,
                  input ready);
  modport sink (input valid, input sample_re, input sample_im, input block_end,
                output ready);
endinterface

interface q15cpc_product_if;
  import q15cpc_pkg::*;

  logic valid;
  logic ready;
  q15_t product_re;
  q15_t product_im;
  logic last;

  modport source (output valid, output product_re, output product_im, output last,
                  input ready);
  modport sink (input valid, input product_re, input product_im, input last,
                output ready);
endinterface

// ===== rtl/q15_complex_product_chain_top.sv =====
// ----------------------------------------------------------------------------
// q15_complex_product_chain_top: product over blocks of q15 factor words
// running real or complex product with saturation, when not stalled one factor word per clock
// ----------------------------------------------------------------------------
// Each input word carries one factor sample. The block multiplies it into a
// running product that starts at 32767+0j, clamps each part to the signed
// 31-bit range and shifts right by 15. After factor_count words (0 counts as
// 1, values above 8 or MAX_FACTOR_VECTORS are capped) one product word is
// sent out, carrying block_end of the word that finished it, and the running
// product restarts. Throughput is one factor word per clock unless a stall
// holds it: the multiply, add and clamp are combinational between the input
// register and the running product register. The word that finishes a
// product passes the input register, then the product waits in the output
// register, where it is valid. The output register lets the next word in
// while a finished product waits to be taken; a stall only backs up once a
// second product is ready to leave. Configuration writes are meant to happen
// while idle.
// ----------------------------------------------------------------------------
module q15_complex_product_chain_top
  import q15cpc_pkg::*;
#(
  parameter int unsigned MAX_FACTOR_VECTORS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  q15cpc_sample_if.sink        sample_i,
  q15cpc_product_if.source     product_o
);

  // factor cap and index width follow from the parameter
  localparam int unsigned CapN = (MAX_FACTOR_VECTORS < HwMaxCount) ?
                                 MAX_FACTOR_VECTORS : HwMaxCount;
  localparam int unsigned IdxW = (CapN > 1) ? $clog2(CapN) : 1;
  localparam logic [CountW-1:0] CapCount = CountW'(CapN);

  // configuration registers
  logic              complex_mode_q;
  logic [CountW-1:0] factor_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      complex_mode_q <= 1'b0;
      factor_count_q <= CountW'(1);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_COMPLEX_MODE: complex_mode_q <= cfg_data_i[0];
        CFG_FACTOR_COUNT: factor_count_q <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // effective factor count: zero means one, capped above
  logic [CountW-1:0] eff_count;
  always_comb begin
    if (factor_count_q == '0) begin
      eff_count = CountW'(1);
    end else if (factor_count_q > CapCount) begin
      eff_count = CapCount;
    end else begin
      eff_count = factor_count_q;
    end
  end

  // input register stage
  logic s1_valid_q;
  q15_t s1_re_q, s1_im_q;
  logic s1_last_q;

  // running product state
  q15_t            run_re_q, run_re_d;
  q15_t            run_im_q, run_im_d;
  logic [IdxW-1:0] idx_q, idx_d;

  // output register
  logic out_valid_q;
  q15_t out_re_q, out_im_q;
  logic out_last_q;

  logic out_free;
  logic s1_finish;
  logic s1_go;
  logic in_take;

  // product finishes once index + 1 reaches the effective count
  assign s1_finish = ({{(CountW + 1 - IdxW){1'b0}}, idx_q} + (CountW + 1)'(1))
                     >= {1'b0, eff_count};
  assign out_free  = !out_valid_q || product_o.ready;
  // a word that does not finish a product never waits on the output side
  assign s1_go     = s1_valid_q && (!s1_finish || out_free);
  assign sample_i.ready = !s1_valid_q || s1_go;
  assign in_take   = sample_i.valid && sample_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (sample_i.ready) begin
      s1_valid_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_re_q   <= sample_i.sample_re;
      s1_im_q   <= sample_i.sample_im;
      s1_last_q <= sample_i.block_end;
    end
  end

  // complex multiply: the imaginary update uses the old real part
  logic signed [2*SampleW-1:0] p_rr, p_ii, p_ri, p_ir;
  wide_t sum_re, sum_im;
  q15_t  new_re, new_im;

  always_comb begin
    p_rr = run_re_q * s1_re_q;
    p_ii = run_im_q * s1_im_q;
    p_ri = run_re_q * s1_im_q;
    p_ir = run_im_q * s1_re_q;
    if (complex_mode_q) begin
      sum_re = SumW'(p_rr) - SumW'(p_ii);
      sum_im = SumW'(p_ri) + SumW'(p_ir);
    end else begin
      // real mode ignores the imaginary parts entirely
      sum_re = SumW'(p_rr);
      sum_im = '0;
    end
    new_re = sat_shift(sum_re);
    new_im = sat_shift(sum_im);
  end

  always_comb begin
    run_re_d = run_re_q;
    run_im_d = run_im_q;
    idx_d    = idx_q;
    if (s1_go) begin
      if (s1_finish) begin
        // restart at about 1.0
        run_re_d = Q15One;
        run_im_d = '0;
        idx_d    = '0;
      end else begin
        run_re_d = new_re;
        run_im_d = new_im;
        idx_d    = idx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_re_q <= Q15One;
      run_im_q <= '0;
      idx_q    <= '0;
    end else begin
      run_re_q <= run_re_d;
      run_im_q <= run_im_d;
      idx_q    <= idx_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_go && s1_finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_finish) begin
      out_re_q   <= new_re;
      out_im_q   <= new_im;
      out_last_q <= s1_last_q;
    end
  end

  assign product_o.valid      = out_valid_q;
  assign product_o.product_re = out_re_q;
  assign product_o.product_im = out_im_q;
  assign product_o.last       = out_last_q;

endmodule
